>>> sv/alarm_table_scheduler_core_assert.svh
// Assertion macros shared by the alarm table scheduler RTL.
`ifndef ALARM_TABLE_SCHEDULER_CORE_ASSERT_SVH
`define ALARM_TABLE_SCHEDULER_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ATS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ATS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ATS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ats_pkg.sv
// Types and constants of the alarm table scheduler.
`timescale 1ns / 1ps

package ats_pkg;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_NEWDAY = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [2:0] KIND_ONCE    = 3'd0;
    localparam logic [2:0] KIND_DAILY   = 3'd1;
    localparam logic [2:0] KIND_WEEKLY  = 3'd2;
    localparam logic [2:0] KIND_MONTHLY = 3'd3;
    localparam logic [2:0] KIND_YEARLY  = 3'd4;
    localparam logic [2:0] KIND_CYCLIC  = 3'd5;
    localparam logic [2:0] KIND_WORKDAY = 3'd6;
    localparam logic [2:0] KIND_WEEKEND = 3'd7;

    localparam logic [2:0]  FIRST_WEEKEND_DAY = 3'd5;
    localparam logic [17:0] FIRE_WINDOW       = 18'd3;
    localparam logic [16:0] SEC_PER_MIN       = 17'd60;
    localparam logic [16:0] TIME_MAX          = 17'h1FFFF;

    typedef struct packed {
        logic [10:0] period;
        logic [2:0]  kind;
        logic [2:0]  weekday;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [16:0] time_sec;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [2:0]  weekday;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } today_t;

    typedef struct packed {
        logic        day_match;
        logic        in_window;
        logic [16:0] next_time;
    } eval_res_t;

endpackage

>>> sv/ats_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ats_eval.sv
// Shared evaluation unit: day match, firing window and cyclic advance of one slot.
`timescale 1ns / 1ps

module ats_eval (
    input  ats_pkg::entry_t    entry,
    input  ats_pkg::today_t    today,
    input  logic [16:0]        now_time,
    output ats_pkg::eval_res_t res
);

    logic        same_day;
    logic        same_month;
    logic        match;
    logic [17:0] window_end;
    logic [16:0] step;
    logic [17:0] sum;

    assign same_day   = (entry.day == today.day);
    assign same_month = (entry.month == today.month);

    always_comb
    begin
        case (entry.kind)
            ats_pkg::KIND_ONCE:    match = same_day && same_month && (entry.year == today.year);
            ats_pkg::KIND_DAILY:   match = 1'b1;
            ats_pkg::KIND_WEEKLY:  match = (entry.weekday == today.weekday);
            ats_pkg::KIND_MONTHLY: match = same_day;
            ats_pkg::KIND_YEARLY:  match = same_day && same_month;
            ats_pkg::KIND_CYCLIC:  match = 1'b1;
            ats_pkg::KIND_WORKDAY: match = (today.weekday < ats_pkg::FIRST_WEEKEND_DAY);
            default:               match = (today.weekday >= ats_pkg::FIRST_WEEKEND_DAY);
        endcase
    end

    // A period of at most 2047 minutes stays within 17 bits of seconds.
    assign window_end = {1'b0, entry.time_sec} + ats_pkg::FIRE_WINDOW;
    assign step       = 17'(17'(entry.period) * ats_pkg::SEC_PER_MIN);
    assign sum        = {1'b0, entry.time_sec} + {1'b0, step};

    always_comb
    begin
        res.day_match = match;
        res.in_window = (now_time >= entry.time_sec) && ({1'b0, now_time} <= window_end);
        res.next_time = sum[17] ? ats_pkg::TIME_MAX : sum[16:0];
    end

endmodule

>>> sv/alarm_table_scheduler_core.sv
// Write and delete are carried out when taken; new day and tick keep s_axis_tready low
// through the walk and the flush, so no further request is taken until both are done,
// and a tick walk is held while the result side holds off a fired slot.
// The walk visits one slot per cycle, unless a hold stops it, through the slot RAM read port and the shared unit.
// Reset clears valid, match and armed flags and sets today to 1/1/0, Monday;
// slot RAM contents are undefined until written.
`timescale 1ns / 1ps

module alarm_table_scheduler_core #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] entry_index, [20:4] time_second, [25:21] date_day, [29:26] date_month,
    // [43:30] date_year, [46:44] weekday, [49:47] alarm_kind, [60:50] period_minutes
    input  logic [63:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] fired_index, [6:4] fired_kind
    output logic [7:0]  m_axis_tdata,
    // last_in_tick
    output logic        m_axis_tlast
);

`include "alarm_table_scheduler_core_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam int XW    = IDX_W + 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t             state_reg,     state_next;
    logic               walk_tick_reg, walk_tick_next;
    logic [PTR_W-1:0]   ptr_reg,       ptr_next;
    logic               eval_vld_reg,  eval_vld_next;
    logic [IDX_W-1:0]   eval_idx_reg,  eval_idx_next;
    logic [16:0]        tick_time_reg, tick_time_next;
    ats_pkg::today_t    today_reg,     today_next;
    logic               changed_reg,   changed_next;
    logic               pend_vld_reg,  pend_vld_next;
    logic [3:0]         pend_idx_reg,  pend_idx_next;
    logic [2:0]         pend_kind_reg, pend_kind_next;
    logic               out_vld_reg,   out_vld_next;
    logic [3:0]         out_idx_reg,   out_idx_next;
    logic [2:0]         out_kind_reg,  out_kind_next;
    logic               out_last_reg,  out_last_next;
    logic [ENTRIES-1:0] valid_reg,     valid_next;
    logic [ENTRIES-1:0] match_reg,     match_next;
    logic [ENTRIES-1:0] armed_reg,     armed_next;

    logic               in_accept;
    logic [1:0]         in_req;
    logic [3:0]         in_index;
    ats_pkg::entry_t    in_entry;
    logic               idx_ok;
    logic [XW-1:0]      wr_idx_x;
    logic [IDX_W-1:0]   wr_idx;
    logic [XW-1:0]      ev_idx_x;
    logic [3:0]         fired_idx;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ats_pkg::ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ats_pkg::ENTRY_W-1:0] ram_rd_data;
    ats_pkg::entry_t    rd_entry;
    ats_pkg::entry_t    cyc_entry;

    ats_pkg::entry_t    unit_entry;
    ats_pkg::eval_res_t unit_res;

    logic               out_free;
    logic               ev_active;
    logic               ev_live;
    logic               hit;
    logic               stall;
    logic               issue;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_index      = s_axis_tdata[3:0];

    always_comb
    begin
        in_entry.time_sec = s_axis_tdata[20:4];
        in_entry.day      = s_axis_tdata[25:21];
        in_entry.month    = s_axis_tdata[29:26];
        in_entry.year     = s_axis_tdata[43:30];
        in_entry.weekday  = s_axis_tdata[46:44];
        in_entry.kind     = s_axis_tdata[49:47];
        in_entry.period   = s_axis_tdata[60:50];
    end

    assign idx_ok    = (32'(in_index) < 32'(ENTRIES));
    assign wr_idx_x  = XW'(in_index);
    assign wr_idx    = wr_idx_x[IDX_W-1:0];
    assign ev_idx_x  = XW'(eval_idx_reg);
    assign fired_idx = ev_idx_x[3:0];

    assign rd_entry  = ats_pkg::entry_t'(ram_rd_data);

    // Writes are checked against the request itself, walks against the slot read back.
    assign unit_entry = (state_reg == ST_IDLE) ? in_entry : rd_entry;

    ats_eval u_eval (
        .entry    (unit_entry),
        .today    (today_reg),
        .now_time (tick_time_reg),
        .res      (unit_res)
    );

    always_comb
    begin
        cyc_entry          = rd_entry;
        cyc_entry.time_sec = unit_res.next_time;
    end

    assign out_free  = !out_vld_reg || m_axis_tready;
    assign ev_active = eval_vld_reg && (state_reg == ST_WALK);
    assign ev_live   = valid_reg[eval_idx_reg] && match_reg[eval_idx_reg]
                       && armed_reg[eval_idx_reg];
    assign hit       = walk_tick_reg && ev_active && ev_live && unit_res.in_window;
    // Hold the walk when a second fired slot finds both holding registers full.
    assign stall     = hit && pend_vld_reg && !out_free;
    assign issue     = (state_reg == ST_WALK) && !stall && (ptr_reg != PTR_W'(ENTRIES));
    assign ram_rd_en = issue;

    ats_ram #(
        .WIDTH (ats_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        walk_tick_next = walk_tick_reg;
        ptr_next       = ptr_reg;
        eval_vld_next  = eval_vld_reg;
        eval_idx_next  = eval_idx_reg;
        tick_time_next = tick_time_reg;
        today_next     = today_reg;
        changed_next   = changed_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_kind_next = pend_kind_reg;
        out_vld_next   = out_vld_reg;
        out_idx_next   = out_idx_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        valid_next     = valid_reg;
        match_next     = match_reg;
        armed_next     = armed_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = wr_idx;
        ram_wr_data    = in_entry;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_req)
                        ats_pkg::REQ_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                ram_wr_en          = 1'b1;
                                valid_next[wr_idx] = 1'b1;
                                match_next[wr_idx] = unit_res.day_match;
                                armed_next[wr_idx] = 1'b1;
                            end
                        end
                        ats_pkg::REQ_DELETE:
                        begin
                            if (idx_ok)
                            begin
                                valid_next[wr_idx] = 1'b0;
                                match_next[wr_idx] = 1'b0;
                                armed_next[wr_idx] = 1'b0;
                            end
                        end
                        ats_pkg::REQ_NEWDAY:
                        begin
                            today_next.day     = in_entry.day;
                            today_next.month   = in_entry.month;
                            today_next.year    = in_entry.year;
                            today_next.weekday = in_entry.weekday;
                            state_next         = ST_WALK;
                            walk_tick_next     = 1'b0;
                            ptr_next           = '0;
                            eval_vld_next      = 1'b0;
                        end
                        default:
                        begin
                            tick_time_next = in_entry.time_sec;
                            changed_next   = 1'b0;
                            state_next     = ST_WALK;
                            walk_tick_next = 1'b1;
                            ptr_next       = '0;
                            eval_vld_next  = 1'b0;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (ev_active && !stall)
                begin
                    if (walk_tick_reg)
                    begin
                        if (hit)
                        begin
                            armed_next[eval_idx_reg] = 1'b0;
                            if (rd_entry.kind == ats_pkg::KIND_ONCE)
                            begin
                                valid_next[eval_idx_reg] = 1'b0;
                                changed_next             = 1'b1;
                            end
                            else if (rd_entry.kind == ats_pkg::KIND_CYCLIC)
                            begin
                                ram_wr_en    = 1'b1;
                                ram_wr_addr  = eval_idx_reg;
                                ram_wr_data  = cyc_entry;
                                changed_next = 1'b1;
                            end
                            // Keep the newest hit back so the last one can be marked.
                            if (pend_vld_reg)
                            begin
                                out_vld_next  = 1'b1;
                                out_idx_next  = pend_idx_reg;
                                out_kind_next = pend_kind_reg;
                                out_last_next = 1'b0;
                            end
                            pend_vld_next  = 1'b1;
                            pend_idx_next  = fired_idx;
                            pend_kind_next = rd_entry.kind;
                        end
                    end
                    else
                    begin
                        if (valid_reg[eval_idx_reg])
                        begin
                            match_next[eval_idx_reg] = unit_res.day_match;
                            armed_next[eval_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            match_next[eval_idx_reg] = 1'b0;
                            armed_next[eval_idx_reg] = 1'b0;
                        end
                    end
                end

                if (!stall)
                begin
                    eval_vld_next = issue;
                    eval_idx_next = ptr_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end

                if (!eval_vld_reg && (ptr_reg == PTR_W'(ENTRIES)))
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // If changed is set, re-arm every live slot; match of a live slot is already current.
                if (changed_reg)
                begin
                    armed_next = valid_reg;
                    match_next = match_reg & valid_reg;
                end
                if (pend_vld_reg)
                begin
                    if (out_free)
                    begin
                        out_vld_next  = 1'b1;
                        out_idx_next  = pend_idx_reg;
                        out_kind_next = pend_kind_reg;
                        out_last_next = 1'b1;
                        pend_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_tick_reg <= 1'b0;
            ptr_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            eval_idx_reg  <= '0;
            tick_time_reg <= '0;
            today_reg     <= '{weekday: 3'd0, year: 14'd0, month: 4'd1, day: 5'd1};
            changed_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            pend_kind_reg <= '0;
            out_vld_reg   <= 1'b0;
            out_idx_reg   <= '0;
            out_kind_reg  <= '0;
            out_last_reg  <= 1'b0;
            valid_reg     <= '0;
            match_reg     <= '0;
            armed_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_tick_reg <= walk_tick_next;
            ptr_reg       <= ptr_next;
            eval_vld_reg  <= eval_vld_next;
            eval_idx_reg  <= eval_idx_next;
            tick_time_reg <= tick_time_next;
            today_reg     <= today_next;
            changed_reg   <= changed_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            pend_kind_reg <= pend_kind_next;
            out_vld_reg   <= out_vld_next;
            out_idx_reg   <= out_idx_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            valid_reg     <= valid_next;
            match_reg     <= match_next;
            armed_reg     <= armed_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_kind_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

    `ATS_ASSERT_ALWAYS(a_armed_needs_valid, clk, rst_n, (armed_reg & ~valid_reg) == '0, "armed slot is not valid")
    `ATS_ASSERT_IMPL(a_idle_no_pending, clk, rst_n, s_axis_tready, !pend_vld_reg, "request taken with a fired slot still held")
    `ATS_ASSERT_NEXT(a_stall_holds_walk, clk, rst_n, stall, $stable(ptr_reg) && $stable(eval_idx_reg), "walk advanced during a hold")
    `ATS_ASSERT_IMPL(a_eval_only_in_walk, clk, rst_n, eval_vld_reg, state_reg == ST_WALK, "evaluation stage live outside the walk")
    `ATS_ASSERT_IMPL(a_walk_write_on_tick, clk, rst_n, ram_wr_en && (state_reg == ST_WALK), walk_tick_reg && hit, "slot RAM written outside a cyclic advance")

endmodule
